// File: design/ppte_pkg.sv
// ----------------------------------------------------------------------------
// ppte_pkg: shared types and constants of the trajectory evaluator
// Table sizes, item codes, control bundles and the coefficient address map.
// ----------------------------------------------------------------------------
package ppte_pkg;

   // Trajectory shape
   localparam int NUM_SEGMENTS = 3;
   localparam int NUM_COEFFS   = 8;
   localparam int NUM_AXES     = 3;
   localparam int NUM_CHAINS   = 5;

   localparam int TBL_DEPTH = NUM_SEGMENTS * NUM_AXES * NUM_COEFFS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int PW_W      = $clog2(NUM_COEFFS);
   localparam int CH_W      = $clog2(NUM_CHAINS);

   // Field widths
   localparam int SEG_W  = 2;
   localparam int AXIS_W = 2;
   localparam int POW_W  = 3;
   localparam int KW     = 3;

   localparam int REQ_TDATA_W = 200;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 192;
   localparam int RSP_TUSER_W = 3;

   // Item kinds
   localparam logic [1:0] KIND_LOAD_COEF = 2'd0;
   localparam logic [1:0] KIND_LOAD_END  = 2'd1;
   localparam logic [1:0] KIND_ODOM      = 2'd2;

   // Horner chains, in evaluation order
   localparam logic [CH_W-1:0] CH_POS_X = 3'd0;
   localparam logic [CH_W-1:0] CH_POS_Y = 3'd1;
   localparam logic [CH_W-1:0] CH_VEL_X = 3'd2;
   localparam logic [CH_W-1:0] CH_VEL_Y = 3'd3;
   localparam logic [CH_W-1:0] CH_VEL_Z = 3'd4;

   localparam logic [63:0] I64_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] I64_MIN = {1'b1, {63{1'b0}}};
   localparam logic [31:0] I32_MAX = {1'b0, {31{1'b1}}};
   localparam logic [31:0] I32_MIN = {1'b1, {31{1'b0}}};

   // Segment end time write
   typedef struct packed {
      logic             en;
      logic [SEG_W-1:0] idx;
      logic [31:0]      value;
   } end_wr_type;

   // Segment search result
   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic             past;
      logic [31:0]      d;
   } seg_info_type;

   // Horner datapath strobes, one per step phase
   typedef struct packed {
      logic load;
      logic absv;
      logic mul_lo;
      logic mul_hi;
      logic rnd;
      logic acc_add;
   } horner_ctl_type;

   // Coefficient table address of (segment, axis, slot)
   function automatic logic [TBL_AW-1:0] coef_addr(input logic [SEG_W-1:0]  seg,
                                                   input logic [AXIS_W-1:0] axis,
                                                   input logic [PW_W-1:0]   pw);
      int unsigned a;
      a = (32'(seg) * NUM_AXES + 32'(axis)) * NUM_COEFFS + 32'(pw);
      return TBL_AW'(a);
   endfunction

endpackage

// File: design/ppte_coef_ram.sv
// ----------------------------------------------------------------------------
// ppte_coef_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppte_coef_ram #(
   parameter int DEPTH = 72,
   parameter int WIDTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ppte_seg_find.sv
// ----------------------------------------------------------------------------
// ppte_seg_find: segment end times and segment search
// Holds the end times and, after go, gives segment and in-segment time.
// ----------------------------------------------------------------------------
module ppte_seg_find
   import ppte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  end_wr_type   end_wr,
   input  logic         go,
   input  logic [31:0]  t,
   output seg_info_type info
);

   logic [31:0]      end_ff [NUM_SEGMENTS];
   logic [31:0]      base [NUM_SEGMENTS];
   logic [SEG_W-1:0] seg_in, seg_ff;
   logic             past_in, past_ff;
   logic [31:0]      a_in, a_ff, b_in, b_ff;
   logic [31:0]      d_in, d_ff;
   logic             go_q_ff;

   // Segment start times: zero, then each previous end
   always_comb begin
      base[0] = '0;
      for (int i = 1; i < NUM_SEGMENTS; i++) begin
         base[i] = end_ff[i-1];
      end
   end

   // Pick segment: past the end holds the last one, else lowest match wins
   always_comb begin
      seg_in  = '0;
      past_in = 1'b0;
      a_in    = t;
      b_in    = '0;
      if (t >= end_ff[NUM_SEGMENTS-1]) begin
         seg_in  = SEG_W'(NUM_SEGMENTS - 1);
         past_in = 1'b1;
         a_in    = end_ff[NUM_SEGMENTS-1];
         b_in    = base[NUM_SEGMENTS-1];
      end else begin
         for (int i = NUM_SEGMENTS - 1; i >= 0; i--) begin
            if (t >= base[i] && t <= end_ff[i]) begin
               seg_in = SEG_W'(i);
               b_in   = base[i];
            end
         end
      end
   end

   // Clamped difference
   assign d_in = (a_ff >= b_ff) ? (a_ff - b_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         go_q_ff <= 1'b0;
      end else begin
         go_q_ff <= go;
      end
   end

   always_ff @(posedge clock) begin
      if (end_wr.en) begin
         end_ff[end_wr.idx] <= end_wr.value;
      end
      if (go) begin
         seg_ff  <= seg_in;
         past_ff <= past_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
      if (go_q_ff) begin
         d_ff <= d_in;
      end
   end

   assign info.seg  = seg_ff;
   assign info.past = past_ff;
   assign info.d    = d_ff;

endmodule

// File: design/ppte_horner.sv
// ----------------------------------------------------------------------------
// ppte_horner: one Horner step unit in Q16.48
// Saturating multiply by Q16.16 time over two passes of a 32x32 multiplier,
// then a saturating add of the (optionally scaled) coefficient.
// ----------------------------------------------------------------------------
module ppte_horner
   import ppte_pkg::*;
(
   input  logic           clock,
   input  horner_ctl_type ctl,
   input  logic [KW-1:0]  k,
   input  logic [31:0]    d,
   input  logic [63:0]    coef,
   output logic [63:0]    acc
);

   logic [63:0] acc_ff, mag_ff, term_ff, plo_ff, phi_ff, r_ff;
   logic        neg_ff;
   logic [63:0] scaled, mag_in, rsum, r_in, add_in;
   logic [31:0] mul_a;
   logic [63:0] prod;
   logic [64:0] sum_in;
   logic [67:0] kprod;

   // Coefficient times k, saturated to 64 bits
   always_comb begin
      kprod = $signed({{4{coef[63]}}, coef}) * $signed({65'd0, k});
      if (kprod[67:63] == '0 || kprod[67:63] == '1) begin
         scaled = kprod[63:0];
      end else begin
         scaled = kprod[67] ? I64_MIN : I64_MAX;
      end
   end

   // Shared unsigned multiplier: low half, then high half of the magnitude
   assign mul_a = ctl.mul_hi ? mag_ff[63:32] : mag_ff[31:0];
   assign prod  = {32'd0, mul_a} * {32'd0, d};

   assign mag_in = acc_ff[63] ? (~acc_ff + 64'd1) : acc_ff;

   // Drop 16 fraction bits, saturate magnitude
   assign rsum = {phi_ff[46:0], 16'd0} + {16'd0, plo_ff[63:16]};
   assign r_in = (phi_ff[63:47] != '0 || rsum[63]) ? I64_MAX : rsum;

   // Apply sign and add term, saturate
   always_comb begin
      sum_in = {term_ff[63], term_ff} + ({1'b0, r_ff} ^ {65{neg_ff}}) + {64'd0, neg_ff};
      if (sum_in[64] != sum_in[63]) begin
         add_in = sum_in[64] ? I64_MIN : I64_MAX;
      end else begin
         add_in = sum_in[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         acc_ff <= scaled;
      end
      if (ctl.absv) begin
         neg_ff <= acc_ff[63];
         mag_ff <= mag_in;
      end
      if (ctl.mul_lo) begin
         plo_ff  <= prod;
         term_ff <= scaled;
      end
      if (ctl.mul_hi) begin
         phi_ff <= prod;
      end
      if (ctl.rnd) begin
         r_ff <= r_in;
      end
      if (ctl.acc_add) begin
         acc_ff <= add_in;
      end
   end

   assign acc = acc_ff;

endmodule

// File: design/piecewise_poly_trajectory_eval.sv
// ----------------------------------------------------------------------------
// piecewise_poly_trajectory_eval: piecewise 7th-order trajectory evaluator
// Coefficient RAM, segment search and a sequencer around one Horner unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per cycle at most; req_tuser selects a coefficient
//   load, a segment end time load or an odometry sample. Loads give no
//   result. The first odometry sample after reset latches the start
//   time and position and gives no result; every later one gives one
//   word on rsp_* with commanded position and velocity.
//   Throughput: a load is taken every cycle while idle. An odometry sample
//   occupies the block through five Horner chains (x/y position, x/y/z
//   velocity), each step passing through the absolute value, the low and
//   high passes of the single 32x32 multiplier (two passes per 64x32
//   product), rounding and the add, plus the coefficient RAM read.
//   req_tready is high only while the sequencer is idle.
//   The result sits in an output register, so a stalled rsp_tready does not
//   stop new loads; a second result waits in the sequencer until the output
//   register is taken.
//   Reset clears the start state and the output valid. The coefficient
//   table and end times come up undefined and must be loaded before use.
// ----------------------------------------------------------------------------
module piecewise_poly_trajectory_eval
   import ppte_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // timestamp, meas_x, meas_y, meas_z, load_segment, load_axis,
   // load_power, load_value, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // cmd_pos_x, cmd_pos_y, cmd_pos_z, cmd_vel_x, cmd_vel_y, cmd_vel_z
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // active_segment, past_end
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   typedef enum logic [12:0] {
      ST_IDLE = 13'h0001,
      ST_TIME = 13'h0002,
      ST_FIND = 13'h0004,
      ST_RD   = 13'h0008,
      ST_INIT = 13'h0010,
      ST_ABS  = 13'h0020,
      ST_MLO  = 13'h0040,
      ST_MHI  = 13'h0080,
      ST_RND  = 13'h0100,
      ST_ADD  = 13'h0200,
      ST_FIN  = 13'h0400,
      ST_PUT  = 13'h0800,
      ST_WAIT = 13'h1000
   } state_type;

   state_type state_in, state_ff;

   logic [1:0]        kind;
   logic [31:0]       timestamp, meas_x, meas_y, meas_z;
   logic [SEG_W-1:0]  load_segment;
   logic [AXIS_W-1:0] load_axis;
   logic [POW_W-1:0]  load_power;
   logic [63:0]       load_value;

   logic              acc_go, coef_wr_en;
   end_wr_type        end_wr;
   logic              started_ff;
   logic [31:0]       start_time_ff;
   logic [31:0]       start_pos_ff [NUM_AXES];
   logic [31:0]       ts_ff, t_rel;
   seg_info_type      seg_info;

   logic [CH_W-1:0]   chain_in, chain_ff;
   logic [PW_W-1:0]   p_in, p_ff, p_last;
   logic              chain_vel;
   logic [AXIS_W-1:0] chain_axis;
   logic [KW-1:0]     k;
   logic              rd_en;
   logic [63:0]       coef;
   logic [63:0]       acc;
   horner_ctl_type    hctl;

   logic [31:0]       res_ff [NUM_CHAINS];
   logic [31:0]       res_in, pos_base;
   logic [32:0]       pos_sum;
   logic              out_free, out_load;
   logic              rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff;

   // Unpack request word
   assign kind         = req_tuser;
   assign timestamp    = req_tdata[31:0];
   assign meas_x       = req_tdata[63:32];
   assign meas_y       = req_tdata[95:64];
   assign meas_z       = req_tdata[127:96];
   assign load_segment = req_tdata[129:128];
   assign load_axis    = req_tdata[131:130];
   assign load_power   = req_tdata[134:132];
   assign load_value   = req_tdata[198:135];

   assign req_tready = (state_ff == ST_IDLE);
   assign acc_go     = req_tvalid && req_tready;

   // Loads, dropped when out of range
   assign coef_wr_en = acc_go && (kind == KIND_LOAD_COEF) &&
                       (32'(load_segment) < NUM_SEGMENTS) &&
                       (32'(load_axis) < NUM_AXES) &&
                       (32'(load_power) < NUM_COEFFS);
   assign end_wr.en    = acc_go && (kind == KIND_LOAD_END) &&
                         (32'(load_segment) < NUM_SEGMENTS);
   assign end_wr.idx   = load_segment;
   assign end_wr.value = load_value[31:0];

   // Start state: first sample latches, later ones are held for evaluation
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff      <= 1'b0;
         start_time_ff   <= '0;
         start_pos_ff[0] <= '0;
         start_pos_ff[1] <= '0;
         start_pos_ff[2] <= '0;
      end else if (acc_go && kind == KIND_ODOM && !started_ff) begin
         started_ff      <= 1'b1;
         start_time_ff   <= timestamp;
         start_pos_ff[0] <= meas_x;
         start_pos_ff[1] <= meas_y;
         start_pos_ff[2] <= meas_z;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_go) begin
         ts_ff <= timestamp;
      end
   end

   // Relative time, clamped at zero
   assign t_rel = (ts_ff >= start_time_ff) ? (ts_ff - start_time_ff) : '0;

   ppte_seg_find u_seg_find (
      .clock (clock),
      .reset (reset),
      .end_wr(end_wr),
      .go    (state_ff == ST_TIME),
      .t     (t_rel),
      .info  (seg_info)
   );

   // Chain decode
   assign chain_vel = (chain_ff >= CH_VEL_X);
   always_comb begin
      case (chain_ff)
         CH_POS_X, CH_VEL_X: chain_axis = AXIS_W'(0);
         CH_POS_Y, CH_VEL_Y: chain_axis = AXIS_W'(1);
         default:            chain_axis = AXIS_W'(2);
      endcase
   end
   assign p_last = chain_vel ? PW_W'(NUM_COEFFS - 2) : PW_W'(NUM_COEFFS - 1);
   assign k      = chain_vel ? (KW'(NUM_COEFFS - 1) - KW'(p_ff)) : KW'(1);

   assign rd_en = (state_ff == ST_RD) || (state_ff == ST_ABS);

   ppte_coef_ram #(
      .DEPTH(TBL_DEPTH),
      .WIDTH(64),
      .AW   (TBL_AW)
   ) u_coef_ram (
      .clock  (clock),
      .wr_en  (coef_wr_en),
      .wr_addr(coef_addr(load_segment, load_axis, PW_W'(load_power))),
      .wr_data(load_value),
      .rd_en  (rd_en),
      .rd_addr(coef_addr(seg_info.seg, chain_axis, p_ff)),
      .rd_data(coef)
   );

   assign hctl.load    = (state_ff == ST_INIT);
   assign hctl.absv    = (state_ff == ST_ABS);
   assign hctl.mul_lo  = (state_ff == ST_MLO);
   assign hctl.mul_hi  = (state_ff == ST_MHI);
   assign hctl.rnd     = (state_ff == ST_RND);
   assign hctl.acc_add = (state_ff == ST_ADD);

   ppte_horner u_horner (
      .clock(clock),
      .ctl  (hctl),
      .k    (k),
      .d    (seg_info.d),
      .coef (coef),
      .acc  (acc)
   );

   // Chain result: Q16.48 floored to Q16.16; positions add the start
   assign pos_base = chain_axis[0] ? start_pos_ff[1] : start_pos_ff[0];
   assign pos_sum  = {pos_base[31], pos_base} + {acc[63], acc[63:32]};
   always_comb begin
      if (!chain_vel) begin
         if (pos_sum[32] != pos_sum[31]) begin
            res_in = pos_sum[32] ? I32_MIN : I32_MAX;
         end else begin
            res_in = pos_sum[31:0];
         end
      end else begin
         res_in = acc[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN) begin
         res_ff[chain_ff] <= res_in;
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign out_load = (state_ff == ST_PUT) && out_free;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      p_in     = p_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_go && kind == KIND_ODOM && started_ff) begin
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            chain_in = CH_POS_X;
            p_in     = '0;
            state_in = ST_FIND;
         end
         ST_FIND: state_in = ST_WAIT;
         ST_WAIT: state_in = ST_RD;
         ST_RD:   state_in = ST_INIT;
         ST_INIT: begin
            if (p_last == '0) begin
               state_in = ST_FIN;
            end else begin
               p_in     = PW_W'(1);
               state_in = ST_ABS;
            end
         end
         ST_ABS: state_in = ST_MLO;
         ST_MLO: state_in = ST_MHI;
         ST_MHI: state_in = ST_RND;
         ST_RND: state_in = ST_ADD;
         ST_ADD: begin
            if (p_ff == p_last) begin
               state_in = ST_FIN;
            end else begin
               p_in     = p_ff + PW_W'(1);
               state_in = ST_ABS;
            end
         end
         ST_FIN: begin
            if (chain_ff == CH_VEL_Z) begin
               state_in = ST_PUT;
            end else begin
               chain_in = chain_ff + CH_W'(1);
               p_in     = '0;
               state_in = ST_RD;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= '0;
         p_ff     <= '0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         p_ff     <= p_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= {res_ff[CH_VEL_Z], res_ff[CH_VEL_Y], res_ff[CH_VEL_X],
                          start_pos_ff[2], res_ff[CH_POS_Y], res_ff[CH_POS_X]};
         rsp_tuser_ff <= {seg_info.past, seg_info.seg};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef ASSERT_OFF
   a_put_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == ST_PUT))
      else $error("result moved on while output register was full");

   a_started_sticks: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("start state lost");

   a_odom_runs: assert property (@(posedge clock) disable iff (reset)
      (acc_go && kind == KIND_ODOM && started_ff) |=> (state_ff == ST_TIME))
      else $error("odometry sample did not start evaluation");

   a_past_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tuser[1:0] == SEG_W'(NUM_SEGMENTS - 1)))
      else $error("past end without last segment");

   a_valid_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_PUT))
      else $error("output valid raised outside result hand-off");
`endif

endmodule
